// ===== design/tlvp_pkg.sv =====
// Shared types and constants for the TLV chain parser.
// Used by every module of the block; no dependencies.
`default_nettype none

package tlvp_pkg;

    localparam int QueueDepth = 4;
    localparam int QueueIdxW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // Chain end status codes
    localparam logic [2:0] ST_RUNNING   = 3'd0;
    localparam logic [2:0] ST_CONSUMED  = 3'd1;
    localparam logic [2:0] ST_LIMIT     = 3'd2;
    localparam logic [2:0] ST_OVERRUN   = 3'd3;
    localparam logic [2:0] ST_HDR_SHORT = 3'd4;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_VALUE,
        PH_STOP
    } tlvp_phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_of_buffer;
        logic [15:0] buffer_length;
    } tlvp_in_t;

    typedef struct packed {
        logic [15:0] entry_type;
        logic [15:0] entry_length;
        logic [7:0]  value_byte;
        logic [15:0] value_offset;
        logic        has_value_byte;
        logic        entry_end;
        logic [15:0] entry_number;
        logic        chain_done;
        logic [2:0]  end_status;
    } tlvp_out_t;

    // Queue status seen by the output stage
    typedef struct packed {
        logic not_empty;
        logic full;
    } tlvp_q_stat_t;

endpackage

`default_nettype wire

// ===== design/tlvp_front.sv =====
// Front end: takes buffer bytes, tracks header/value phase and counters,
// and builds one result record per byte that produces one. Uses tlvp_pkg.
`default_nettype none

module tlvp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire tlvp_pkg::tlvp_in_t  in_data,
    input  wire logic [15:0]       max_entries,
    output logic                   push,
    output tlvp_pkg::tlvp_out_t    push_data
);
    import tlvp_pkg::*;

    tlvp_phase_t phase_reg, phase_next;
    logic [23:0] hdr_reg, hdr_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] seen_reg, seen_next;

    logic        accept;
    logic        emit;
    tlvp_out_t   res;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STOP;
            hdr_reg   <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            pos_reg   <= '0;
            seen_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
        end
    end

    always_comb
    begin
        logic [15:0] num;
        logic [15:0] off;
        logic        done_early;

        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        emit       = 1'b0;
        res        = '0;
        num        = '0;
        off        = '0;
        done_early = 1'b0;

        // A start byte restarts the chain
        if (in_data.start_of_buffer)
        begin
            seen_next  = '0;
            hdr_next   = '0;
            type_next  = '0;
            len_next   = '0;
            pos_next   = '0;
            rem_next   = in_data.buffer_length;
            phase_next = PH_HDR0;
            if (in_data.buffer_length == 16'd0)
            begin
                phase_next     = PH_STOP;
                emit           = 1'b1;
                res.chain_done = 1'b1;
                res.end_status = ST_CONSUMED;
                done_early     = 1'b1;
            end
        end

        if (!done_early)
        begin
            if (phase_next == PH_STOP || rem_next == 16'd0)
            begin
                // drop bytes after the chain has ended
                phase_next = PH_STOP;
            end
            else
            begin
                rem_next = rem_next - 16'd1;
                unique case (phase_next)
                    PH_HDR0, PH_HDR1, PH_HDR2:
                    begin
                        hdr_next   = {hdr_next[15:0], in_data.data_byte};
                        phase_next = tlvp_phase_t'(phase_next + 3'd1);
                        if (rem_next == 16'd0)
                        begin
                            phase_next       = PH_STOP;
                            emit             = 1'b1;
                            res.entry_number = seen_next;
                            res.chain_done   = 1'b1;
                            res.end_status   = ST_HDR_SHORT;
                        end
                    end
                    PH_HDR3:
                    begin
                        type_next  = hdr_next[23:8];
                        len_next   = {hdr_next[7:0], in_data.data_byte};
                        pos_next   = '0;
                        phase_next = PH_VALUE;
                        if (len_next == 16'd0)
                        begin
                            num              = seen_next;
                            seen_next        = seen_next + 16'd1;
                            emit             = 1'b1;
                            res.entry_type   = type_next;
                            res.entry_end    = 1'b1;
                            res.entry_number = num;
                        end
                        else if (len_next > rem_next)
                        begin
                            phase_next       = PH_STOP;
                            emit             = 1'b1;
                            res.entry_type   = type_next;
                            res.entry_length = len_next;
                            res.entry_number = seen_next;
                            res.chain_done   = 1'b1;
                            res.end_status   = ST_OVERRUN;
                        end
                    end
                    PH_VALUE:
                    begin
                        off                = pos_next;
                        num                = seen_next;
                        pos_next           = pos_next + 16'd1;
                        emit               = 1'b1;
                        res.entry_type     = type_next;
                        res.entry_length   = len_next;
                        res.value_byte     = in_data.data_byte;
                        res.value_offset   = off;
                        res.has_value_byte = 1'b1;
                        res.entry_number   = num;
                        if (pos_next == len_next)
                        begin
                            seen_next     = seen_next + 16'd1;
                            res.entry_end = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_STOP;
                    end
                endcase

                // Entry complete: limit first, then buffer end
                if (res.entry_end)
                begin
                    if (max_entries != 16'd0 && seen_next == max_entries)
                    begin
                        phase_next     = PH_STOP;
                        res.chain_done = 1'b1;
                        res.end_status = ST_LIMIT;
                    end
                    else if (rem_next == 16'd0)
                    begin
                        phase_next     = PH_STOP;
                        res.chain_done = 1'b1;
                        res.end_status = ST_CONSUMED;
                    end
                    else
                    begin
                        phase_next = PH_HDR0;
                    end
                end
            end
        end
    end

    assign push      = accept && emit;
    assign push_data = res;

endmodule

`default_nettype wire

// ===== design/tlvp_queue.sv =====
// Small result queue between the front end and the output stage.
// Register storage, one push and one pop per cycle. Uses tlvp_pkg.
`default_nettype none

module tlvp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire tlvp_pkg::tlvp_out_t push_data,
    input  wire logic                pop,
    output tlvp_pkg::tlvp_out_t      head_data,
    output tlvp_pkg::tlvp_q_stat_t   stat
);
    import tlvp_pkg::*;

    tlvp_out_t              mem_reg [QueueDepth];
    logic [QueueIdxW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QueueIdxW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign head_data      = mem_reg[rd_ptr_reg];
    assign stat.not_empty = (cnt_reg != '0);
    assign stat.full      = (cnt_reg == QueueCntW'(QueueDepth));

endmodule

`default_nettype wire

// ===== design/tlvp_back.sv =====
// Output stage: pops results from the queue into the output register
// and presents them on the valid/ready channel. Uses tlvp_pkg.
`default_nettype none

module tlvp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tlvp_pkg::tlvp_q_stat_t stat,
    input  wire tlvp_pkg::tlvp_out_t head_data,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tlvp_pkg::tlvp_out_t      out_data
);
    import tlvp_pkg::*;

    logic      valid_reg, valid_next;
    tlvp_out_t data_reg;

    // Advance when the register is empty or its transfer completes
    assign pop = stat.not_empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== design/tlv_chain_parser.sv =====
// TLV chain parser top level: front end, result queue, output stage.
// Throughput: one byte per cycle; in_ready drops only while the 4-entry queue is full.
// A result goes through the queue, then the output register that drives out_valid.
// Reset: parser stopped, queue empty, output invalid, max_entries cleared to 0.
// Uses tlvp_pkg, tlvp_front, tlvp_queue, tlvp_back.
`default_nettype none

module tlv_chain_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tlvp_pkg::tlvp_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tlvp_pkg::tlvp_out_t      out_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data
);
    import tlvp_pkg::*;

    logic [15:0]  max_entries_reg;
    logic         push;
    logic         pop;
    tlvp_out_t    push_data;
    tlvp_out_t    head_data;
    tlvp_q_stat_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            max_entries_reg <= cfg_wr_data;
        end
    end

    assign in_ready = !q_stat.full;

    tlvp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .max_entries (max_entries_reg),
        .push        (push),
        .push_data   (push_data)
    );

    tlvp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .stat      (q_stat)
    );

    tlvp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (q_stat),
        .head_data (head_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== design/tlvp_checker.sv =====
// Port-level checks for the TLV chain parser, bound to the top level.
// Uses tlvp_pkg.
`default_nettype none

module tlvp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire tlvp_pkg::tlvp_out_t out_data
);
    import tlvp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.chain_done == (out_data.end_status != ST_RUNNING))
        else $error("chain_done disagrees with end_status");

    a_no_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.has_value_byte |->
            out_data.value_byte == 8'd0 && out_data.value_offset == 16'd0)
        else $error("value fields set without a value byte");

    a_value_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.has_value_byte |->
            out_data.value_offset < out_data.entry_length)
        else $error("value offset beyond entry length");

endmodule

bind tlv_chain_parser tlvp_checker u_tlvp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/tlv_chain_parser_test.sv =====
// Self-checking testbench for tlv_chain_parser: random byte buffers are streamed in and every
// parsed result is compared field by field against a byte-serial TLV parser kept in the bench.
// Depends on tlvp_pkg and the tlv_chain_parser RTL.
`timescale 1ns / 100ps

module tlv_chain_parser_test;

    import tlvp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    tlvp_in_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    tlvp_out_t   out_data;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    tlv_chain_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Parser state mirrored in the bench
    tlvp_phase_t parse_state = PH_STOP;
    logic [23:0] hdr_shift = '0;
    logic [15:0] cur_type = '0;
    logic [15:0] cur_len = '0;
    logic [15:0] bytes_left = '0;
    logic [15:0] val_pos = '0;
    logic [15:0] entry_count = '0;
    logic [15:0] entry_limit = '0;

    tlvp_in_t    buffer_bytes_q[$];
    tlvp_out_t   parsed_results_due[$];
    logic [7:0]  chain_bytes[$];

    bit          in_accepted = 1'b0;
    bit          drain_wait = 1'b0;
    int          send_gap = 0;
    int          send_burst = 0;
    int          bytes_sent = 0;
    int          stall_left = 0;
    int          ready_burst = 0;
    int          error_count = 0;
    tlvp_out_t   want;

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tlv_chain_parser_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    // Count a completed entry and decide whether the chain stops here.
    function automatic logic [2:0] close_entry();
        entry_count = entry_count + 16'd1;
        if (entry_limit != 16'd0 && entry_count == entry_limit)
        begin
            parse_state = PH_STOP;
            return ST_LIMIT;
        end
        if (bytes_left == 16'd0)
        begin
            parse_state = PH_STOP;
            return ST_CONSUMED;
        end
        parse_state = PH_HDR0;
        return ST_RUNNING;
    endfunction

    task automatic parse_tlv_byte(input tlvp_in_t item);
        tlvp_out_t   res;
        logic [2:0]  st;
        res = '0;
        if (item.start_of_buffer)
        begin
            entry_count = '0;
            hdr_shift = '0;
            cur_type = '0;
            cur_len = '0;
            val_pos = '0;
            bytes_left = item.buffer_length;
            parse_state = PH_HDR0;
            if (bytes_left == 16'd0)
            begin
                // empty buffer: status only, start byte dropped
                parse_state = PH_STOP;
                res.chain_done = 1'b1;
                res.end_status = ST_CONSUMED;
                parsed_results_due.push_back(res);
                return;
            end
        end
        if (parse_state == PH_STOP || bytes_left == 16'd0)
        begin
            parse_state = PH_STOP;
            return;
        end
        bytes_left = bytes_left - 16'd1;

        if (parse_state == PH_HDR0 || parse_state == PH_HDR1 || parse_state == PH_HDR2)
        begin
            hdr_shift = {hdr_shift[15:0], item.data_byte};
            parse_state = tlvp_phase_t'(parse_state + 1);
            if (bytes_left == 16'd0)
            begin
                parse_state = PH_STOP;
                res.entry_number = entry_count;
                res.chain_done = 1'b1;
                res.end_status = ST_HDR_SHORT;
                parsed_results_due.push_back(res);
            end
            return;
        end

        if (parse_state == PH_HDR3)
        begin
            cur_type = hdr_shift[23:8];
            cur_len = {hdr_shift[7:0], item.data_byte};
            val_pos = '0;
            if (cur_len == 16'd0)
            begin
                res.entry_number = entry_count;
                st = close_entry();
                res.entry_type = cur_type;
                res.entry_end = 1'b1;
                res.chain_done = (st != ST_RUNNING);
                res.end_status = st;
                parsed_results_due.push_back(res);
            end
            else if (cur_len > bytes_left)
            begin
                parse_state = PH_STOP;
                res.entry_type = cur_type;
                res.entry_length = cur_len;
                res.entry_number = entry_count;
                res.chain_done = 1'b1;
                res.end_status = ST_OVERRUN;
                parsed_results_due.push_back(res);
            end
            else
            begin
                parse_state = PH_VALUE;
            end
            return;
        end

        res.entry_type = cur_type;
        res.entry_length = cur_len;
        res.value_byte = item.data_byte;
        res.value_offset = val_pos;
        res.has_value_byte = 1'b1;
        res.entry_number = entry_count;
        val_pos = val_pos + 16'd1;
        if (val_pos == cur_len)
        begin
            st = close_entry();
            res.entry_end = 1'b1;
            res.chain_done = (st != ST_RUNNING);
            res.end_status = st;
        end
        parsed_results_due.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_error(input string msg);
        error_count = error_count + 1;
        if (error_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string fname, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
            flag_error($sformatf("%s mismatch: expected %h, got %h", fname, exp_v, act_v));
    endtask

    // Check the output transfer first, then model the input transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (parsed_results_due.size() == 0)
                begin
                    flag_error($sformatf("result with nothing expected: %h", out_data));
                end
                else
                begin
                    want = parsed_results_due.pop_front();
                    check_field("entry_type", want.entry_type, out_data.entry_type);
                    check_field("entry_length", want.entry_length, out_data.entry_length);
                    check_field("value_byte", 16'(want.value_byte),
                                16'(out_data.value_byte));
                    check_field("value_offset", want.value_offset, out_data.value_offset);
                    check_field("has_value_byte", 16'(want.has_value_byte),
                                16'(out_data.has_value_byte));
                    check_field("entry_end", 16'(want.entry_end), 16'(out_data.entry_end));
                    check_field("entry_number", want.entry_number, out_data.entry_number);
                    check_field("chain_done", 16'(want.chain_done),
                                16'(out_data.chain_done));
                    check_field("end_status", 16'(want.end_status),
                                16'(out_data.end_status));
                end
            end
            in_accepted = in_valid && in_ready;
            if (in_accepted)
                parse_tlv_byte(in_data);
        end
    end

    // ------------------------------------------------------------------
    // Driver and receiver
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 999);
        if (roll < 550)
            return 0;
        if (roll < 850)
            return $urandom_range(1, 2);
        if (roll < 970)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_accepted))
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (drain_wait)
            begin
                // hold until every outstanding result has been taken
                if (parsed_results_due.size() == 0)
                    drain_wait = 1'b0;
                in_valid <= 1'b0;
            end
            else if (buffer_bytes_q.size() != 0)
            begin
                in_data <= buffer_bytes_q.pop_front();
                in_valid <= 1'b1;
                bytes_sent = bytes_sent + 1;
                if (send_burst > 0)
                begin
                    send_burst = send_burst - 1;
                    send_gap = 0;
                end
                else
                begin
                    send_gap = pick_gap();
                    if ($urandom_range(0, 63) == 0)
                        send_burst = $urandom_range(30, 120);
                end
                if (bytes_sent % 300 == 150 || $urandom_range(0, 199) == 0)
                    drain_wait = 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (ready_burst > 0)
                    ready_burst = ready_burst - 1;
                else if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
                else if ($urandom_range(0, 99) == 0)
                    ready_burst = $urandom_range(40, 150);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_item(input logic [7:0] d, input logic sob, input logic [15:0] blen);
        tlvp_in_t item;
        item.data_byte = d;
        item.start_of_buffer = sob;
        // buffer_length is ignored off the start byte; scramble it there
        item.buffer_length = sob ? blen : 16'($urandom_range(0, 65535));
        buffer_bytes_q.push_back(item);
    endtask

    task automatic append_entry(input logic [15:0] typ, input logic [15:0] len);
        int k;
        chain_bytes.push_back(typ[15:8]);
        chain_bytes.push_back(typ[7:0]);
        chain_bytes.push_back(len[15:8]);
        chain_bytes.push_back(len[7:0]);
        for (k = 0; k < len; k++)
            chain_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_chain(input logic [15:0] blen, input bit with_start);
        int k;
        if (chain_bytes.size() == 0)
            chain_bytes.push_back(8'($urandom_range(0, 255)));
        for (k = 0; k < chain_bytes.size(); k++)
            push_item(chain_bytes[k], with_start && k == 0, blen);
        chain_bytes.delete();
    endtask

    function automatic logic [15:0] pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return 16'd0;
        if (roll < 80)
            return 16'($urandom_range(1, 4));
        if (roll < 95)
            return 16'($urandom_range(5, 16));
        if (roll < 99)
            return 16'($urandom_range(17, 80));
        return 16'($urandom_range(150, 300));
    endfunction

    task automatic random_buffer(output int counted);
        int n;
        int k;
        int total;
        int kind;
        int blen;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
            append_entry(16'($urandom_range(0, 65535)), pick_len());
        total = chain_bytes.size();
        kind = $urandom_range(0, 99);
        if (kind < 72)
        begin
            send_chain(16'(total), 1'b1);
            counted = total;
            // trailing bytes after the chain ends are dropped
            if ($urandom_range(0, 3) == 0)
                for (k = $urandom_range(1, 4); k > 0; k--)
                    push_item(8'($urandom_range(0, 255)), 1'b0, 16'd0);
        end
        else if (kind < 82)
        begin
            // cut short: ends in a header or under a value
            blen = $urandom_range(1, total - 1);
            send_chain(16'(blen), 1'b1);
            counted = blen;
        end
        else if (kind < 88)
        begin
            // declared longer than sent; the next start restarts parsing
            send_chain(16'(total + $urandom_range(1, 12)), 1'b1);
            counted = total;
        end
        else if (kind < 94)
        begin
            chain_bytes.delete();
            blen = $urandom_range(1, 12);
            for (k = 0; k < blen; k++)
                chain_bytes.push_back(8'($urandom_range(0, 255)));
            send_chain(16'(blen), 1'b1);
            counted = blen;
        end
        else
        begin
            // stray bytes with no start
            chain_bytes.delete();
            for (k = $urandom_range(1, 6); k > 0; k--)
                push_item(8'($urandom_range(0, 255)), 1'b0, 16'd0);
            counted = 0;
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (buffer_bytes_q.size() != 0 || in_valid || parsed_results_due.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        entry_limit = v;
    endtask

    initial
    begin
        logic [15:0] limits[6];
        int          phase;
        int          got;
        int          counted;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero-length buffer
        send_chain(16'd0, 1'b1);
        // Empty entry with all-ones type, then all-zeros type with extreme value bytes
        append_entry(16'hFFFF, 16'd0);
        chain_bytes.push_back(8'h00);
        chain_bytes.push_back(8'h00);
        chain_bytes.push_back(8'h00);
        chain_bytes.push_back(8'h02);
        chain_bytes.push_back(8'hFF);
        chain_bytes.push_back(8'h00);
        send_chain(16'd10, 1'b1);
        // Header cut short
        chain_bytes.push_back(8'h12);
        chain_bytes.push_back(8'h34);
        send_chain(16'd2, 1'b1);
        // Value overrun at the largest buffer length, then a byte while stopped
        append_entry(16'hA5A5, 16'd0);
        chain_bytes[2] = 8'hFF;
        chain_bytes[3] = 8'hFF;
        send_chain(16'hFFFF, 1'b1);
        push_item(8'hC3, 1'b0, 16'd0);
        wait_idle();

        // Limit and buffer end on the same entry
        write_limit(16'd1);
        append_entry(16'h5A5A, 16'd1);
        send_chain(16'd5, 1'b1);
        wait_idle();

        // Limit changed while a buffer is half parsed
        write_limit(16'd0);
        append_entry(16'h0101, 16'd0);
        append_entry(16'h0202, 16'd0);
        append_entry(16'h0303, 16'd0);
        send_chain(16'd22, 1'b1);
        wait_idle();
        write_limit(16'd2);
        append_entry(16'h0404, 16'd1);
        send_chain(16'd0, 1'b0);
        wait_idle();
        write_limit(16'd5);
        append_entry(16'h0505, 16'd1);
        send_chain(16'd0, 1'b0);
        wait_idle();

        limits[0] = 16'd0;
        limits[1] = 16'd1;
        limits[2] = 16'hFFFF;
        limits[3] = 16'd3;
        limits[4] = 16'($urandom_range(2, 6));
        limits[5] = 16'd0;
        for (phase = 0; phase < 6; phase++)
        begin
            write_limit(limits[phase]);
            got = 0;
            while (got < 175)
            begin
                random_buffer(counted);
                got = got + counted;
            end
            wait_idle();
        end

        repeat (10) @(negedge clk);
        if (error_count == 0 && parsed_results_due.size() == 0)
            $display("tlv_chain_parser_test: PASS");
        else
            $display("tlv_chain_parser_test: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/tlvp_pkg.sv
design/tlvp_front.sv
design/tlvp_queue.sv
design/tlvp_back.sv
design/tlv_chain_parser.sv
design/tlvp_checker.sv
tb/sv/tlv_chain_parser_test.sv
